@@ sv/mbrot_pkg.sv @@
// Shared types and constants for the escape-time pixel engine.
// Depends on nothing; imported by every module of the block but the multiplier.
package mbrot_pkg;

  localparam int FRAC_BITS_DEF = 26;
  localparam int MAX_DIM_DEF   = 4096;

  localparam int COL_W  = 12;   // column and row index width
  localparam int STEP_W = 29;   // pixel pitch register width
  localparam int ITER_W = 16;   // iteration count width
  localparam int IDX_W  = 2;    // config register index width
  localparam int IN_W   = 24;   // input tdata width
  localparam int OUT_W  = 16;   // output tdata width

  localparam logic [STEP_W-1:0] STEP_RE_RST  = STEP_W'(229600);
  localparam logic [STEP_W-1:0] STEP_IM_RST  = STEP_W'(174991);
  localparam logic [ITER_W-1:0] ITER_CAP_RST = ITER_W'(256);

  // config register indexes
  localparam logic [IDX_W-1:0] REG_STEP_RE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_STEP_IM  = 2'd1;
  localparam logic [IDX_W-1:0] REG_ITER_CAP = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CR, S_CI, S_CIL, S_BOX, S_M1, S_M2, S_M3, S_M4,
    S_IT_A, S_IT_B, S_IT_C, S_IT_D, S_DONE
  } state_t;

  // operand pair presented to the shared multiplier
  typedef enum logic [3:0] {
    MS_NONE, MS_COL, MS_ROW, MS_CI2, MS_CRM2, MS_CRP2, MS_QQ,
    MS_ZR2, MS_ZI2, MS_ZRZI
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    mul_sel_t mul_sel;
    logic     ld_cr;
    logic     ld_ci;
    logic     ld_cisq;
    logic     ld_q;
    logic     ld_bulb;
    logic     ld_a;
    logic     ld_b;
    logic     step_z;
    logic     set_max;
    logic     ld_out;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic box_ok;
    logic in_set;
    logic n_lt_max;
    logic z_small;
    logic mag_ok;
    logic out_free;
  } stat_t;

endpackage

@@ sv/mbrot_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on nothing; used by the top level for every product.
module mbrot_mul #(
  parameter int MW = 31
) (
  input  logic                   clk,
  input  logic signed [MW-1:0]   a,
  input  logic signed [MW-1:0]   b,
  output logic signed [2*MW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (2*MW)'(a) * (2*MW)'(b);
  end

endmodule

@@ sv/mbrot_ctrl.sv @@
// Sequencer for the escape-time engine: picks multiplier operands and
// register loads each cycle. Depends on mbrot_pkg.
module mbrot_ctrl
  import mbrot_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t st,
  output ctrl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (st.in_valid) state_next = S_CR;
      S_CR:   state_next = S_CI;
      S_CI:   state_next = S_CIL;
      S_CIL:  state_next = S_BOX;
      S_BOX:  state_next = st.box_ok ? S_M1 : S_IT_A;
      S_M1:   state_next = S_M2;
      S_M2:   state_next = S_M3;
      S_M3:   state_next = S_M4;
      S_M4:   state_next = st.in_set ? S_DONE : S_IT_A;
      S_IT_A: state_next = (st.n_lt_max && st.z_small) ? S_IT_B : S_DONE;
      S_IT_B: state_next = S_IT_C;
      S_IT_C: state_next = S_IT_D;
      S_IT_D: state_next = st.mag_ok ? S_IT_A : S_DONE;
      S_DONE: if (st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.mul_sel = MS_NONE;
    unique case (state)
      S_IDLE: ctl.in_ready = 1'b1;
      S_CR:   ctl.mul_sel = MS_COL;
      S_CI: begin
        ctl.mul_sel = MS_ROW;
        ctl.ld_cr   = 1'b1;
      end
      S_CIL:  ctl.ld_ci = 1'b1;
      S_BOX:  ctl.mul_sel = MS_CI2;
      S_M1: begin
        ctl.ld_cisq = 1'b1;
        ctl.mul_sel = MS_CRM2;
      end
      S_M2: begin
        ctl.ld_q    = 1'b1;
        ctl.mul_sel = MS_CRP2;
      end
      S_M3: begin
        ctl.ld_bulb = 1'b1;
        ctl.mul_sel = MS_QQ;
      end
      S_M4:   ctl.set_max = st.in_set;
      S_IT_A: ctl.mul_sel = MS_ZR2;
      S_IT_B: begin
        ctl.ld_a    = 1'b1;
        ctl.mul_sel = MS_ZI2;
      end
      S_IT_C: begin
        ctl.ld_b    = 1'b1;
        ctl.mul_sel = MS_ZRZI;
      end
      S_IT_D: ctl.step_z = st.mag_ok;
      S_DONE: ctl.ld_out = st.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

@@ sv/mandelbrot_escape_time.sv @@
// Escape-time pixel engine: one pixel in, one iteration count out.
// Every iteration needs three products in turn from the single shared multiplier,
// plus an update state. One item at a time: the next pixel can be taken in the
// cycle after the result is loaded, not before. Reset (rst, synchronous) restores
// pitch and cap registers.
module mandelbrot_escape_time
  import mbrot_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // item in: column [11:0], row [23:12]
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,
  // item out: iteration_count [15:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,
  // config write port
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [STEP_W-1:0] cfg_data
);

  // c and z width: sign, 4 integer bits, fraction (holds +-8)
  localparam int CW = FRAC_BITS + 5;
  // multiplier operand width; also fits pixel index times pitch
  localparam int MW = (CW > STEP_W + 1) ? CW : STEP_W + 1;
  localparam int PW = 2 * MW;

  localparam logic signed [PW-1:0] ONE      = PW'(1) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] TWO      = ONE <<< 1;
  localparam logic signed [PW-1:0] LIM4     = ONE <<< 2;
  localparam logic signed [PW-1:0] NEG_LIM4 = -LIM4;
  localparam logic signed [PW-1:0] LIM8     = ONE <<< 3;
  localparam logic signed [PW-1:0] RE_ORG   = -(((ONE <<< 2) + ONE) >>> 1);
  localparam logic signed [PW-1:0] ONE_SQ   = ONE <<< FRAC_BITS;
  localparam logic signed [PW-1:0] BULB_LIM = ONE_SQ >>> 4;
  localparam logic signed [PW-1:0] MAG_LIM  = ONE_SQ <<< 2;
  localparam logic signed [MW-1:0] ONE_M    = MW'(1) <<< FRAC_BITS;
  localparam logic signed [MW-1:0] QTR_M    = ONE_M >>> 2;
  localparam logic [31:0]          DIM_TOP  = 32'(MAX_DIM - 1);

  function automatic logic signed [PW-1:0] sat(input logic signed [PW-1:0] v,
                                               input logic signed [PW-1:0] lim);
    logic signed [PW-1:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

  // configuration registers
  logic [STEP_W-1:0] step_re, step_im;
  logic [ITER_W-1:0] iter_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_re  <= STEP_RE_RST;
      step_im  <= STEP_IM_RST;
      iter_cap <= ITER_CAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_RE:  step_re  <= cfg_data;
        REG_STEP_IM:  step_im  <= cfg_data;
        REG_ITER_CAP: iter_cap <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  ctrl_t ctl;
  stat_t st;

  mbrot_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .ctl (ctl)
  );

  // pixel indexes, saturated to the image size
  logic [COL_W-1:0] col_in, row_in, col_sat, row_sat, col, row;
  logic             in_acc;

  assign col_in  = s_axis_tdata[COL_W-1:0];
  assign row_in  = s_axis_tdata[2*COL_W-1:COL_W];
  assign col_sat = ({{(32-COL_W){1'b0}}, col_in} > DIM_TOP) ? DIM_TOP[COL_W-1:0] : col_in;
  assign row_sat = ({{(32-COL_W){1'b0}}, row_in} > DIM_TOP) ? DIM_TOP[COL_W-1:0] : row_in;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = ctl.in_ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      col <= col_sat;
      row <= row_sat;
    end
  end

  // datapath registers
  logic signed [CW-1:0] cr, ci, q, zr, zi;
  logic signed [PW-1:0] cisq, a, b;
  logic                 bulb;
  logic [ITER_W-1:0]    n;

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] p;

  mbrot_mul #(.MW(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  logic signed [MW-1:0] cr_m, ci_m, zr_m, zi_m, crm, crp, qpc;
  logic signed [PW-1:0] cr_w, ci_w, zr_w, zi_w;

  assign cr_m = MW'(cr);
  assign ci_m = MW'(ci);
  assign zr_m = MW'(zr);
  assign zi_m = MW'(zi);
  assign cr_w = PW'(cr);
  assign ci_w = PW'(ci);
  assign zr_w = PW'(zr);
  assign zi_w = PW'(zi);
  assign crm  = cr_m - QTR_M;
  assign crp  = cr_m + ONE_M;
  assign qpc  = MW'(q) + crm;

  always_comb begin
    unique case (ctl.mul_sel)
      MS_COL: begin
        mul_a = MW'(col);
        mul_b = MW'(step_re);
      end
      MS_ROW: begin
        mul_a = MW'(row);
        mul_b = MW'(step_im);
      end
      MS_CI2: begin
        mul_a = ci_m;
        mul_b = ci_m;
      end
      MS_CRM2: begin
        mul_a = crm;
        mul_b = crm;
      end
      MS_CRP2: begin
        mul_a = crp;
        mul_b = crp;
      end
      MS_QQ: begin
        mul_a = MW'(q);
        mul_b = qpc;
      end
      MS_ZR2: begin
        mul_a = zr_m;
        mul_b = zr_m;
      end
      MS_ZI2: begin
        mul_a = zi_m;
        mul_b = zi_m;
      end
      MS_ZRZI: begin
        mul_a = zr_m;
        mul_b = zi_m;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // next values from the registered product
  logic signed [PW-1:0] cr_next, ci_next, q_sum, zr_next, zi_next;

  assign cr_next = sat(p + RE_ORG, LIM8);
  assign ci_next = sat(p - ONE, LIM8);
  assign q_sum   = p + cisq;
  assign zr_next = sat(((a - b) >>> FRAC_BITS) + cr_w, LIM4);
  assign zi_next = sat((p >>> (FRAC_BITS - 1)) + ci_w, LIM4);

  always_ff @(posedge clk) begin
    if (ctl.ld_cr)   cr   <= cr_next[CW-1:0];
    if (ctl.ld_ci)   ci   <= ci_next[CW-1:0];
    if (ctl.ld_cisq) cisq <= p;
    if (ctl.ld_q)    q    <= CW'(q_sum >>> FRAC_BITS);
    if (ctl.ld_bulb) bulb <= (q_sum <= BULB_LIM);   // (cr+1)^2 + ci^2 <= 1/16
    if (ctl.ld_a)    a    <= p;
    if (ctl.ld_b)    b    <= p;
  end

  // z and count: cleared per pixel, reset so the bound checks start clean
  always_ff @(posedge clk) begin
    if (rst) begin
      zr <= '0;
      zi <= '0;
      n  <= '0;
    end else if (in_acc) begin
      zr <= '0;
      zi <= '0;
      n  <= '0;
    end else if (ctl.set_max) begin
      n <= iter_cap;
    end else if (ctl.step_z) begin
      zr <= zr_next[CW-1:0];
      zi <= zi_next[CW-1:0];
      n  <= n + ITER_W'(1);
    end
  end

  // status back to the sequencer
  assign st.in_valid = s_axis_tvalid;
  assign st.box_ok   = (cr_w <= TWO) && (cr_w >= -TWO) && (ci_w <= TWO) && (ci_w >= -TWO);
  // main cardioid: 4*q*(q + cr - 1/4) <= ci^2
  assign st.in_set   = bulb || ((p <<< 2) <= cisq);
  assign st.n_lt_max = n < iter_cap;
  assign st.z_small  = (zr_w <= TWO) && (zr_w >= -TWO) && (zi_w <= TWO) && (zi_w >= -TWO);
  assign st.mag_ok   = (a + b) <= MAG_LIM;
  assign st.out_free = !m_axis_tvalid || m_axis_tready;

  // output register: holds the count until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.ld_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) m_axis_tdata <= n;
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("second item taken while busy");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (n <= iter_cap))
    else $error("count ran past cap");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata <= iter_cap))
    else $error("result above cap");

  a_z_bound: assert property (@(posedge clk) disable iff (rst)
    (zr_w <= LIM4) && (zr_w >= NEG_LIM4) && (zi_w <= LIM4) && (zi_w >= NEG_LIM4))
    else $error("z left saturation range");

endmodule

@@ tb/sv/mandelbrot_escape_time_checker.sv @@
// Checker for the escape-time pixel engine: watches the pixel, result and config ports,
// predicts each iteration count and compares it with what the block hands out.
// Depends on mbrot_pkg for widths, register indexes and reset values.
module escape_time_checker
  import mbrot_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // column [11:0], row [23:12]
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [OUT_W-1:0]  m_axis_tdata,   // iteration_count [15:0]
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [STEP_W-1:0] cfg_data,
  output int                mismatches,
  output int                pending
);

  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [COL_W-1:0]  row;
    logic [ITER_W-1:0] count;
  } pixel_count_t;

  logic [STEP_W-1:0] pitch_re;
  logic [STEP_W-1:0] pitch_im;
  logic [ITER_W-1:0] iter_cap;
  pixel_count_t      expected_counts[$];
  int                err_count = 0;

  function automatic wide_t mul_wide(longint signed x, longint signed y);
    wide_t xw, yw;
    xw = x;
    yw = y;
    return xw * yw;
  endfunction

  function automatic longint signed sat(longint signed v, longint signed lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint signed mag(longint signed v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint signed low64(wide_t v);
    return v[63:0];
  endfunction

  function automatic logic [ITER_W-1:0] predict_escape_count(logic [COL_W-1:0] column,
                                                             logic [COL_W-1:0] row);
    longint signed unit, cr, ci, zr, zi, crm, crp, q, re_next, im_next;
    wide_t         ci_sq, zr_sq, zi_sq;
    int unsigned   n;
    bit            in_set;
    unit   = longint'(1) << FRAC;
    zr     = 0;
    zi     = 0;
    n      = 0;
    in_set = 1'b0;
    // a 12-bit index never passes MAX_DIM - 1, so no index clamp
    cr = longint'(column) * longint'(pitch_re) - (longint'(5) << (FRAC - 1));
    ci = longint'(row) * longint'(pitch_im) - unit;
    cr = sat(cr, 8 * unit);
    ci = sat(ci, 8 * unit);
    // cardioid and period-2 bulb only inside the +-2 box
    if (mag(cr) <= 2 * unit && mag(ci) <= 2 * unit) begin
      crm   = cr - (unit >>> 2);
      crp   = cr + unit;
      ci_sq = mul_wide(ci, ci);
      q     = low64((mul_wide(crm, crm) + ci_sq) >>> FRAC);
      if ((mul_wide(q, q + crm) <<< 2) <= ci_sq) in_set = 1'b1;
      if (mul_wide(crp, crp) + ci_sq <= (wide_t'(1) <<< (2 * FRAC - 4))) in_set = 1'b1;
    end
    if (in_set) return iter_cap;
    while (n < iter_cap) begin
      if (mag(zr) > 2 * unit || mag(zi) > 2 * unit) break;
      zr_sq = mul_wide(zr, zr);
      zi_sq = mul_wide(zi, zi);
      if (zr_sq + zi_sq > (wide_t'(1) <<< (2 * FRAC + 2))) break;
      n++;
      re_next = low64((zr_sq - zi_sq) >>> FRAC);
      im_next = low64(mul_wide(zr, zi) >>> (FRAC - 1));
      zr      = sat(re_next + cr, 4 * unit);
      zi      = sat(im_next + ci, 4 * unit);
    end
    return ITER_W'(n);
  endfunction

  always @(posedge clk) begin : watch
    pixel_count_t want;
    if (rst) begin
      pitch_re = STEP_RE_RST;
      pitch_im = STEP_IM_RST;
      iter_cap = ITER_CAP_RST;
      expected_counts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_RE:  pitch_re = cfg_data;
          REG_STEP_IM:  pitch_im = cfg_data;
          REG_ITER_CAP: iter_cap = cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want.column = s_axis_tdata[COL_W-1:0];
        want.row    = s_axis_tdata[2*COL_W-1:COL_W];
        want.count  = predict_escape_count(want.column, want.row);
        expected_counts.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_counts.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: result item with none expected, iteration_count %0d",
                     $time, m_axis_tdata);
        end else begin
          want = expected_counts.pop_front();
          if (m_axis_tdata[ITER_W-1:0] !== want.count) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: pixel (%0d,%0d) iteration_count expected %0d, got %0d",
                       $time, want.column, want.row, want.count, m_axis_tdata);
          end
        end
      end
    end
    mismatches <= err_count;
    pending    <= expected_counts.size();
  end

endmodule

@@ tb/sv/tb_mandelbrot_escape_time.sv @@
// Top of the escape-time pixel engine testbench: drives pixels, config writes and
// result stalls, and gives the verdict. Depends on mbrot_pkg, mandelbrot_escape_time
// and escape_time_checker.
module tb_mandelbrot_escape_time;
  import mbrot_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int STALL_PCT     = 23;     // idle chance per cycle on either side
  localparam int IDLE_LIMIT    = 50000;  // above the slowest pixel at cap 1000
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 80;
  localparam int GRID_PCT      = 85;     // share of pixels inside the framed view

  localparam logic [IDX_W-1:0]  REG_SPARE       = 2'd3;
  localparam int unsigned       SPAN_RE         = 234881024;  // 3.5 in Q6.26
  localparam int unsigned       SPAN_IM         = 134217728;  // 2.0 in Q6.26
  localparam logic [STEP_W-1:0] PITCH_SIXTEENTH = STEP_W'(1 << (FRAC_BITS_DEF - 4));
  localparam logic [STEP_W-1:0] PITCH_MAX       = '1;
  localparam logic [ITER_W-1:0] CAP_SHORT       = ITER_W'(20);

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;    // column [11:0], row [23:12]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;          // iteration_count [15:0]
  logic              cfg_we        = 1'b0;
  logic [IDX_W-1:0]  cfg_index     = '0;
  logic [STEP_W-1:0] cfg_data      = '0;

  logic calm     = 1'b0;  // no idling on either side while set
  logic squeeze  = 1'b0;  // asks the receiver for its one long hold
  logic squeezed = 1'b0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;
  int   mismatches;
  int   pending;

  always #HALF_PERIOD clk = ~clk;

  mandelbrot_escape_time DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  escape_time_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // Result side: random stalls, one long hold on request (counted here), and no
  // stalls at all while calm is set.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (squeeze && !squeezed) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      squeezed      <= 1'b1;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // Watchdog: any item or config write restarts the count.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_mandelbrot_escape_time: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write per edge; the caller lowers cfg_we after the last one,
  // so cfg_we is never dropped and raised in the same step.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_view(input logic [STEP_W-1:0] re, input logic [STEP_W-1:0] im,
                          input logic [STEP_W-1:0] cap_word);
    write_reg(REG_STEP_RE, re);
    write_reg(REG_STEP_IM, im);
    write_reg(REG_ITER_CAP, cap_word);
    cfg_we <= 1'b0;
  endtask

  // Offers one pixel, with random gaps unless calm; returns at the accepting edge
  // with tvalid still high so back-to-back items need no extra NBA.
  task automatic send_pixel(input logic [COL_W-1:0] column, input logic [COL_W-1:0] row);
    while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, column};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Sender pause: nothing offered until every predicted count has come back.
  // The first edge lets pending catch up with an item taken at the previous one.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned       w, h, pick;
    logic [STEP_W-1:0] re, im;
    logic [ITER_W-1:0] cap;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset pitches and cap: one escaping corner, one point near the origin
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd700, 12'd383);
    drain();

    // 1/16 per pixel: column 40 is cr = 0, row 16 is ci = 0
    set_view(PITCH_SIXTEENTH, PITCH_SIXTEENTH, STEP_W'(CAP_SHORT));
    send_pixel(12'd0, 12'd0);          // left of the box, cr = -2.5
    send_pixel(12'd4095, 12'd4095);    // both parts of c saturate
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd40, 12'd16);        // origin, inside the cardioid
    send_pixel(12'd24, 12'd16);        // bulb centre, c = -1
    send_pixel(12'd8, 12'd16);         // c = -2: |z|^2 sits exactly on 4
    send_pixel(12'd44, 12'd16);        // cardioid cusp, c = 0.25
    send_pixel(12'd45, 12'd16);        // just past the cusp, slow escape
    send_pixel(12'd40, 12'd48);        // c = 2i, on the box edge
    send_pixel(12'd2730, 12'd1365);    // alternating bit patterns
    send_pixel(12'd1365, 12'd2730);
    drain();

    // zero cap: every pixel gives 0
    set_view(PITCH_SIXTEENTH, PITCH_SIXTEENTH, '0);
    send_pixel(12'd40, 12'd16);
    drain();

    set_view(PITCH_SIXTEENTH, PITCH_SIXTEENTH, STEP_W'(1));
    send_pixel(12'd45, 12'd16);
    drain();

    // top cap via an all-ones word, upper bits dropped; only quick pixels here
    set_view(PITCH_SIXTEENTH, PITCH_SIXTEENTH, PITCH_MAX);
    send_pixel(12'd40, 12'd16);
    send_pixel(12'd24, 12'd16);
    send_pixel(12'd45, 12'd16);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // write to the unused index must leave the cap alone
    write_reg(REG_SPARE, '0);
    cfg_we <= 1'b0;
    send_pixel(12'd40, 12'd16);
    drain();

    // pitch extremes
    set_view(PITCH_MAX, '0, STEP_W'(CAP_SHORT));
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd1);
    drain();
    set_view(STEP_W'(1), STEP_W'(1), STEP_W'(CAP_SHORT));
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);

    // Random views: mostly a framed picture of the set at a random size, now and
    // then random pitches; caps mostly short, a few long ones.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      calm <= (p == 1);
      w = $urandom_range(2, MAX_DIM_DEF);
      h = $urandom_range(2, MAX_DIM_DEF);
      if ($urandom_range(0, 5) == 0) begin
        re = STEP_W'($urandom_range(1, PITCH_MAX));
        im = STEP_W'($urandom_range(1, PITCH_MAX));
      end else begin
        re = STEP_W'(SPAN_RE / (w - 1));
        im = STEP_W'(SPAN_IM / (h - 1));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)      cap = ITER_W'(1);
      else if (pick == 1) cap = ITER_W'($urandom_range(300, 1000));
      else                cap = ITER_W'($urandom_range(2, 128));
      if (p % 4 == 3) write_reg(REG_SPARE, STEP_W'($urandom));
      set_view(re, im, {13'($urandom), cap});
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long result hold while pixels keep coming, so the input backs up
        if (p == 3 && i == 3) squeeze <= 1'b1;
        if ($urandom_range(0, 99) < GRID_PCT)
          send_pixel(COL_W'($urandom_range(0, w - 1)), COL_W'($urandom_range(0, h - 1)));
        else
          send_pixel(COL_W'($urandom), COL_W'($urandom));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_mandelbrot_escape_time: done, clean");
    end else begin
      $display("tb_mandelbrot_escape_time: done, errors");
    end
    $finish;
  end

endmodule
